@@ src/acsc_pkg.sv @@
// Shared types and constants for the ack/retry sender controller.
`default_nettype none

package acsc_pkg;

  // Field widths
  localparam int DevW    = 8;
  localparam int ShiftW  = 16;
  localparam int TmoW    = 16;
  localparam int RetryW  = 8;
  localparam int TimeW   = 24;
  localparam int SensorW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 24;
  localparam int OutDatW = 24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEVICE_ID      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TIME_SHIFT_MS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RECEIPT_TMO_MS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RETRY_LIMIT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLEEP_MS       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SENSOR_COUNT   = 3'd5;

  // Reset values of the registers
  localparam logic [TmoW-1:0]   RST_RECEIPT_TMO = 16'd1000;
  localparam logic [RetryW-1:0] RST_RETRY_LIMIT = 8'd3;
  localparam logic [TimeW-1:0]  RST_SLEEP_MS    = 24'd60000;

  // Saturation point of the millisecond counter
  localparam logic [TimeW-1:0] ELAPSED_MAX = {TimeW{1'b1}};

  // Input beat kinds
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_RECEIPT = 1'b1;

  // Controller modes
  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_REST  = 2'd2
  } mode_t;

  // Register file contents plus the precomputed retry stagger
  typedef struct packed {
    logic [DevW-1:0]    device_id;
    logic [TmoW-1:0]    receipt_timeout_ms;
    logic [RetryW-1:0]  retry_limit;
    logic [TimeW-1:0]   sleep_ms;
    logic [SensorW-1:0] sensor_count;
    logic [TimeW-1:0]   stagger_ms;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic               receipt_matched;
    logic [7:0]         fail_count;
    logic [1:0]         mode;
    logic [SensorW-1:0] sensor_index;
    logic               send_now;
  } res_t;

endpackage

`default_nettype wire

@@ src/acsc_cfg.sv @@
// Configuration register file and registered stagger product.
`default_nettype none

module acsc_cfg
  import acsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [CfgDatW-1:0] wr_data,
  output cfg_t                    cfg
);

  logic [DevW-1:0]    device_id;
  logic [ShiftW-1:0]  time_shift_ms;
  logic [TmoW-1:0]    receipt_timeout_ms;
  logic [RetryW-1:0]  retry_limit;
  logic [TimeW-1:0]   sleep_ms;
  logic [SensorW-1:0] sensor_count;
  logic [TimeW-1:0]   stagger_ms;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id          <= '0;
      time_shift_ms      <= '0;
      receipt_timeout_ms <= RST_RECEIPT_TMO;
      retry_limit        <= RST_RETRY_LIMIT;
      sleep_ms           <= RST_SLEEP_MS;
      sensor_count       <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEVICE_ID:      device_id          <= wr_data[DevW-1:0];
        REG_TIME_SHIFT_MS:  time_shift_ms      <= wr_data[ShiftW-1:0];
        REG_RECEIPT_TMO_MS: receipt_timeout_ms <= wr_data[TmoW-1:0];
        REG_RETRY_LIMIT:    retry_limit        <= wr_data[RetryW-1:0];
        REG_SLEEP_MS:       sleep_ms           <= wr_data[TimeW-1:0];
        REG_SENSOR_COUNT:   sensor_count       <= wr_data[SensorW-1:0];
        default: ;
      endcase
    end
  end

  // 16x8 product, registered; fits 24 bits exactly
  always_ff @(posedge clk) begin
    if (rst) begin
      stagger_ms <= '0;
    end else begin
      stagger_ms <= TimeW'(time_shift_ms * device_id);
    end
  end

  assign cfg.device_id          = device_id;
  assign cfg.receipt_timeout_ms = receipt_timeout_ms;
  assign cfg.retry_limit        = retry_limit;
  assign cfg.sleep_ms           = sleep_ms;
  assign cfg.sensor_count       = sensor_count;
  assign cfg.stagger_ms         = stagger_ms;

endmodule

`default_nettype wire

@@ src/acsc_step.sv @@
// Controller state and the combinational step for one tick or receipt.
`default_nettype none

module acsc_step
  import acsc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            op,
  input  wire logic [DevW-1:0] dest,
  input  wire cfg_t            cfg,
  output res_t                 res
);

  mode_t              mode_reg, mode_reg_next;
  logic [TimeW-1:0]   elapsed_ms, elapsed_ms_next;
  logic [TimeW-1:0]   send_wait_ms, send_wait_ms_next;
  logic [SensorW-1:0] sensor_pos, sensor_pos_next;
  logic [7:0]         fail_counter, fail_counter_next;
  logic               receipt_flag, receipt_flag_next;

  logic [TimeW-1:0]   elapsed_inc;
  logic [SensorW:0]   pos_inc;
  logic [8:0]         fails_inc;
  logic               send_now;
  logic               matched;

  assign elapsed_inc = (elapsed_ms == ELAPSED_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
  assign pos_inc     = {1'b0, sensor_pos} + 1'b1;
  assign fails_inc   = {1'b0, fail_counter} + 1'b1;

  // Next-state logic
  always_comb begin
    mode_reg_next     = mode_reg;
    elapsed_ms_next   = elapsed_ms;
    send_wait_ms_next = send_wait_ms;
    sensor_pos_next   = sensor_pos;
    fail_counter_next = fail_counter;
    receipt_flag_next = receipt_flag;
    send_now          = 1'b0;
    matched           = 1'b0;

    if (op == OP_RECEIPT) begin
      if (dest == cfg.device_id) begin
        receipt_flag_next = 1'b1;
        matched           = 1'b1;
      end
    end else begin
      elapsed_ms_next = elapsed_inc;
      if (cfg.sensor_count != '0) begin
        unique case (mode_reg)
          MODE_WAIT: begin
            if (receipt_flag) begin
              fail_counter_next = '0;
              elapsed_ms_next   = '0;
              if (pos_inc >= {1'b0, cfg.sensor_count}) begin
                sensor_pos_next = '0;
                mode_reg_next   = MODE_REST;
              end else begin
                sensor_pos_next   = pos_inc[SensorW-1:0];
                send_wait_ms_next = '0;
                mode_reg_next     = MODE_SEND;
              end
            end else if (elapsed_inc > TimeW'(cfg.receipt_timeout_ms)) begin
              elapsed_ms_next = '0;
              if (fails_inc < {1'b0, cfg.retry_limit}) begin
                fail_counter_next = fails_inc[7:0];
                send_wait_ms_next = cfg.stagger_ms;
                mode_reg_next     = MODE_SEND;
              end else begin
                fail_counter_next = '0;
                mode_reg_next     = MODE_REST;
              end
            end
          end
          MODE_REST: begin
            if (elapsed_inc > cfg.sleep_ms) begin
              mode_reg_next   = MODE_SEND;
              elapsed_ms_next = '0;
            end
          end
          default: begin
            // send pending; the unused code falls in here too
            mode_reg_next = MODE_SEND;
            if (elapsed_inc > send_wait_ms) begin
              receipt_flag_next = 1'b0;
              mode_reg_next     = MODE_WAIT;
              send_now          = 1'b1;
              elapsed_ms_next   = '0;
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg     <= MODE_SEND;
      elapsed_ms   <= '0;
      send_wait_ms <= '0;
      sensor_pos   <= '0;
      fail_counter <= '0;
      receipt_flag <= 1'b0;
    end else if (en) begin
      mode_reg     <= mode_reg_next;
      elapsed_ms   <= elapsed_ms_next;
      send_wait_ms <= send_wait_ms_next;
      sensor_pos   <= sensor_pos_next;
      fail_counter <= fail_counter_next;
      receipt_flag <= receipt_flag_next;
    end
  end

  // Result fields reflect the state after the step
  assign res.send_now        = send_now;
  assign res.sensor_index    = sensor_pos_next;
  assign res.mode            = mode_reg_next;
  assign res.fail_count      = fail_counter_next;
  assign res.receipt_matched = matched;

endmodule

`default_nettype wire

@@ src/ack_retry_sender_controller_top.sv @@
// Top level of the ack/retry sender controller: beat registers around the step.
//
//  channel | dir | beat fields
//  s_*     | in  | tuser: operation; tdata: receipt_device
//  m_*     | out | tdata: send_now, sensor_index, mode, fail_count, receipt_matched
//  cfg_*   | in  | cfg_index: register number; cfg_data: value
//
// One beat per cycle sustained while m_tready is high; a result passes through the input
// register, then the step logic into the result register.
// The retry stagger product is registered in the cycle after a device_id or
// time_shift_ms write. Reset is synchronous and clears all control state.
// A stalled result holds; one more input beat is taken in behind it.
`default_nettype none

module ack_retry_sender_controller_top
  import acsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input stream
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] receipt_device
  input  wire logic               s_tuser,   // [0] operation
  // result stream
  output      logic               m_tvalid,
  input  wire logic               m_tready,
  output      logic [OutDatW-1:0] m_tdata,   // [0] send_now, [8:1] sensor_index,
                                             // [10:9] mode, [18:11] fail_count,
                                             // [19] receipt_matched, [23:20] zero
  // configuration writes
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_data
);

  cfg_t            cfg;
  res_t            res;
  logic            in_valid;
  logic            in_op;
  logic [DevW-1:0] in_dest;
  logic            advance;
  res_t            out_res;

  assign cfg_ready = 1'b1;

  acsc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: step fires when the result register is free or draining
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_dest <= s_tdata;
    end
  end

  acsc_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .op   (in_op),
    .dest (in_dest),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {4'b0, out_res.receipt_matched, out_res.fail_count, out_res.mode,
                    out_res.sensor_index, out_res.send_now};

endmodule

`default_nettype wire

@@ src/acsc_checker.sv @@
// Port-level checks for the ack/retry sender controller, bound to the top level.
`default_nettype none

module acsc_sva
  import acsc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [OutDatW-1:0] m_tdata
);

  // No result right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its data
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A send request always leaves the controller waiting for a receipt
  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[10:9] == MODE_WAIT)
    else $error("send without entering wait mode");

  // A receipt match and a send request never share a beat
  a_match_no_send: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19] |-> !m_tdata[0])
    else $error("receipt beat carries a send request");

  // Mode field never shows the unused code
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:9] != 2'd3)
    else $error("unused mode code on result");

endmodule

bind ack_retry_sender_controller_top acsc_sva u_acsc_sva (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
